// File: src/assert_macros.svh
// Assertion macros shared by the RTL. Each macro expects clk in scope; ASSERT_CLK also expects arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property checked on every clock edge, also while reset is held.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: src/kls_pkg.sv
package kls_pkg;

	// Fixed field widths.
	localparam int ROW_W       = 4;
	localparam int COL_W       = 4;
	localparam int CODE_W      = 8;
	localparam int TICK_W      = 16;
	localparam int HOLD_W      = 12;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int FRAME_BITS  = 8;
	localparam int BIT_IDX_W   = 4;
	localparam int KEYS        = 16;

	// Default geometry of the keypad.
	localparam int DEF_ROWS = 4;
	localparam int DEF_COLS = 4;

	// Register reset values.
	localparam logic [TICK_W-1:0] RST_SCAN_GAP  = 16'd120;
	localparam logic [TICK_W-1:0] RST_DEBOUNCE  = 16'd120;
	localparam logic [TICK_W-1:0] RST_HOLD_STEP = 16'd24;
	localparam logic [HOLD_W-1:0] RST_HOLD_STEPS = 12'd295;
	localparam logic [TICK_W-1:0] RST_BIT_TICKS = 16'd10;

	// ASCII anchors for hex digits.
	localparam logic [CODE_W-1:0] ASCII_ZERO = 8'h30;
	localparam logic [CODE_W-1:0] ASCII_A    = 8'h41;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCAN_GAP  = 3'd0,
		REG_DEBOUNCE  = 3'd1,
		REG_HOLD_STEP = 3'd2,
		REG_HOLD_STEPS = 3'd3,
		REG_BIT_TICKS = 3'd4
	} cfg_reg_t;

	// Scanner phases.
	typedef enum logic [1:0] {
		PH_GAP,
		PH_SETTLE,
		PH_HOLD,
		PH_TX
	} phase_t;

	// One result beat.
	typedef struct packed {
		logic [COL_W-1:0]  column_drive;
		logic              carrier_on;
		logic              key_sent;
		logic [CODE_W-1:0] key_code;
		logic              transmitting;
	} result_t;

	// ASCII hex digit of a key number.
	function automatic logic [CODE_W-1:0] hex_code(input logic [3:0] n);
		logic [CODE_W-1:0] nz;
		nz = {4'd0, n};
		if (n < 4'd10) begin
			return ASCII_ZERO + nz;
		end else begin
			return ASCII_A + (nz - 8'd10);
		end
	endfunction

endpackage

// File: src/kls_in_if.sv
interface kls_in_if import kls_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] row_levels;

	modport source (output valid, output row_levels, input ready);
	modport sink (input valid, input row_levels, output ready);

endinterface

// File: src/kls_out_if.sv
interface kls_out_if import kls_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [COL_W-1:0]  column_drive;
	logic              carrier_on;
	logic              key_sent;
	logic [CODE_W-1:0] key_code;
	logic              transmitting;

	modport source (
		output valid, output column_drive, output carrier_on, output key_sent,
		output key_code, output transmitting, input ready
	);
	modport sink (
		input valid, input column_drive, input carrier_on, input key_sent,
		input key_code, input transmitting, output ready
	);

endinterface

// File: src/keypad_longpress_serial_sender.sv
// Channel   | Dir | Payload                                              | Beat
// ----------+-----+------------------------------------------------------+-----------------
// in_ch     | in  | row_levels                                           | one base tick
// out_ch    | out | column_drive, carrier_on, key_sent, key_code,        | state after tick
//           |     | transmitting                                         |
// cfg port  | in  | cfg_we, cfg_index, cfg_wdata                         | one register write
//
// One input beat per clock while in_ch.ready is high; its result beat is registered in the output buffer.
// The scanner state is updated by one pass of compare and flag logic per accepted beat.
// A two-entry output buffer (output register plus skid) lets input flow while out_ch stalls;
// in_ch.ready drops only when both entries are full.
// arst_n clears the scanner state, the registers to their defaults, and the output buffer.
`include "assert_macros.svh"

module keypad_longpress_serial_sender import kls_pkg::*; #(
	parameter int ROWS = DEF_ROWS,
	parameter int COLS = DEF_COLS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	kls_in_if.sink                in_ch,
	kls_out_if.source             out_ch
);

	// Configuration registers.
	logic [TICK_W-1:0] scan_gap_q, debounce_q, hold_step_q, bit_ticks_q;
	logic [HOLD_W-1:0] hold_steps_q;

	// Scanner state.
	phase_t               phase_q, phase_d;
	logic [TICK_W-1:0]    tick_q, tick_d;
	logic [HOLD_W-1:0]    hold_q, hold_d;
	logic [1:0]           row_q, row_d;
	logic [1:0]           col_q, col_d;
	logic [KEYS-1:0]      pressed_q, pressed_d;
	logic [3:0]           prev_q, prev_d;
	logic [CODE_W-1:0]    frame_q, frame_d;
	logic [BIT_IDX_W-1:0] bit_q, bit_d;
	logic                 sending_q, sending_d;
	logic                 carrier_q, carrier_d;
	logic [CODE_W-1:0]    last_q, last_d;

	// Per-beat working signals.
	logic              in_fire;
	logic              sent_c;
	logic              fire;
	logic              advance;
	logic              released;
	logic [3:0]        key;
	logic [TICK_W-1:0] period;
	logic [TICK_W:0]   tick_inc;
	logic [2:0]        row_inc;
	logic [2:0]        col_inc;
	logic [CODE_W-1:0] code;
	result_t           res_c;

	// Output buffer.
	result_t out_q, skid_q;
	logic    out_v_q, skid_v_q;
	logic    out_free;

	assign in_ch.ready = !skid_v_q;
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_free    = !out_v_q || out_ch.ready;

	// Register writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_gap_q   <= RST_SCAN_GAP;
			debounce_q   <= RST_DEBOUNCE;
			hold_step_q  <= RST_HOLD_STEP;
			hold_steps_q <= RST_HOLD_STEPS;
			bit_ticks_q  <= RST_BIT_TICKS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCAN_GAP:   scan_gap_q   <= cfg_wdata;
				REG_DEBOUNCE:   debounce_q   <= cfg_wdata;
				REG_HOLD_STEP:  hold_step_q  <= cfg_wdata;
				REG_HOLD_STEPS: hold_steps_q <= cfg_wdata[HOLD_W-1:0];
				REG_BIT_TICKS:  bit_ticks_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Next state for one tick.
	always_comb begin
		phase_d   = phase_q;
		hold_d    = hold_q;
		row_d     = row_q;
		col_d     = col_q;
		pressed_d = pressed_q;
		prev_d    = prev_q;
		frame_d   = frame_q;
		bit_d     = bit_q;
		sending_d = sending_q;
		carrier_d = carrier_q;
		last_d    = last_q;
		sent_c    = 1'b0;
		advance   = 1'b0;

		key      = {row_q, col_q};
		released = in_ch.row_levels[row_q];
		code     = hex_code(key);

		unique case (phase_q)
			PH_GAP:    period = scan_gap_q;
			PH_SETTLE: period = debounce_q;
			PH_HOLD:   period = hold_step_q;
			PH_TX:     period = bit_ticks_q;
		endcase

		// A wait fires once the count reaches its period; a zero period acts as one.
		tick_inc = {1'b0, tick_q} + 17'd1;
		fire     = tick_inc >= {1'b0, period};
		tick_d   = fire ? '0 : tick_inc[TICK_W-1:0];

		unique case (phase_q)
			PH_GAP: begin
				if (fire) begin
					for (int r = 0; r < 4; r++) begin
						prev_d[r] = pressed_q[{2'(r), col_q}];
					end
					phase_d = PH_SETTLE;
				end
			end
			PH_SETTLE: begin
				if (fire) begin
					if (!released) begin
						pressed_d[key] = 1'b1;
						hold_d         = '0;
						phase_d        = PH_HOLD;
					end else begin
						pressed_d[key] = 1'b0;
						advance        = 1'b1;
					end
				end
			end
			PH_HOLD: begin
				if (fire) begin
					if (hold_q < hold_steps_q) begin
						hold_d = hold_q + 12'd1;
						// Early release clears the key and ends the hold at the next sample.
						if (released) begin
							pressed_d[key] = 1'b0;
							hold_d         = hold_steps_q;
						end
					end else begin
						hold_d = '0;
						if (pressed_q[key] && !prev_q[row_q]) begin
							last_d    = code;
							frame_d   = code;
							sending_d = 1'b1;
							sent_c    = 1'b1;
						end
						advance = 1'b1;
					end
				end
			end
			PH_TX: begin
				if (fire) begin
					if (bit_q >= BIT_IDX_W'(FRAME_BITS)) begin
						carrier_d = 1'b0;
						bit_d     = '0;
						sending_d = 1'b0;
						phase_d   = PH_GAP;
					end else begin
						carrier_d = !frame_q[bit_q[2:0]];
						bit_d     = bit_q + 4'd1;
					end
				end
			end
		endcase

		// Step to the next row, or close the column and start a frame if one is pending.
		row_inc = {1'b0, row_q} + 3'd1;
		col_inc = {1'b0, col_q} + 3'd1;
		if (advance) begin
			if (row_inc < 3'(ROWS) && !sending_d) begin
				row_d   = row_inc[1:0];
				phase_d = PH_SETTLE;
			end else begin
				row_d = '0;
				col_d = (col_inc >= 3'(COLS)) ? 2'd0 : col_inc[1:0];
				if (sending_d) begin
					phase_d   = PH_TX;
					carrier_d = 1'b1;
					bit_d     = '0;
				end else begin
					phase_d = PH_GAP;
				end
			end
		end
	end

	// Result fields from the state after the tick.
	always_comb begin
		res_c.column_drive = (phase_d == PH_SETTLE || phase_d == PH_HOLD) ?
			(COL_W'(1) << col_d) : '0;
		res_c.carrier_on   = carrier_d;
		res_c.key_sent     = sent_c;
		res_c.key_code     = last_d;
		res_c.transmitting = sending_d;
	end

	// Scanner state registers, advanced once per accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_GAP;
			tick_q    <= '0;
			hold_q    <= '0;
			row_q     <= '0;
			col_q     <= '0;
			pressed_q <= '0;
			prev_q    <= '0;
			frame_q   <= '0;
			bit_q     <= '0;
			sending_q <= 1'b0;
			carrier_q <= 1'b0;
			last_q    <= '0;
		end else if (in_fire) begin
			phase_q   <= phase_d;
			tick_q    <= tick_d;
			hold_q    <= hold_d;
			row_q     <= row_d;
			col_q     <= col_d;
			pressed_q <= pressed_d;
			prev_q    <= prev_d;
			frame_q   <= frame_d;
			bit_q     <= bit_d;
			sending_q <= sending_d;
			carrier_q <= carrier_d;
			last_q    <= last_d;
		end
	end

	// Output buffer valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_v_q <= 1'b1;
		end
	end

	// Output buffer payload.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (in_fire) begin
				out_q <= res_c;
			end
		end
		if (in_fire && !out_free) begin
			skid_q <= res_c;
		end
	end

	assign out_ch.valid        = out_v_q;
	assign out_ch.column_drive = out_q.column_drive;
	assign out_ch.carrier_on   = out_q.carrier_on;
	assign out_ch.key_sent     = out_q.key_sent;
	assign out_ch.key_code     = out_q.key_code;
	assign out_ch.transmitting = out_q.transmitting;

	`ASSERT_CLK(a_skid_behind_out, skid_v_q |-> out_v_q, "skid entry without output entry")
	`ASSERT_CLK(a_tx_matches_sending, (phase_q == PH_TX) == sending_q, "frame flag out of step")
	`ASSERT_CLK(a_carrier_in_frame, carrier_q |-> sending_q, "carrier on outside a frame")
	`ASSERT_CLK(a_latch_starts_frame, (in_fire && sent_c) |=> (phase_q == PH_TX && bit_q == '0), "no frame")
	`ASSERT_CLK(a_out_held, (out_v_q && !out_ch.ready) |=> (out_v_q && $stable(out_q)), "stall lost")

endmodule

// File: bench/keypad_longpress_serial_sender_tb.sv
`timescale 1ns / 1ps

module keypad_longpress_serial_sender_tb;
	import kls_pkg::*;

	// Register indexes past the end of the register file; writes there are dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLDOFF_CYCLES = 60;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	kls_in_if in_ch ();
	kls_out_if out_ch ();

	keypad_longpress_serial_sender dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Row samples waiting to be sent and scanner outputs waiting to be seen.
	logic [ROW_W-1:0] row_stream[$];
	result_t tick_results[$];

	int errors = 0;
	int ticks_sent = 0;
	int beats_checked = 0;
	int keys_latched = 0;
	int cycle_count = 0;

	// Scanner copy: register settings.
	logic [TICK_W-1:0] gap_ticks;
	logic [TICK_W-1:0] settle_ticks;
	logic [TICK_W-1:0] step_ticks;
	logic [HOLD_W-1:0] press_samples;
	logic [TICK_W-1:0] baud_ticks;

	// Scanner copy: state.
	phase_t scan_phase;
	logic [TICK_W-1:0] wait_count;
	logic [HOLD_W-1:0] hold_samples;
	logic [1:0] cur_row;
	logic [1:0] cur_col;
	logic [KEYS-1:0] key_down;
	logic [3:0] col_snapshot;
	logic [CODE_W-1:0] tx_shift;
	logic [BIT_IDX_W-1:0] tx_bit;
	logic tx_busy;
	logic carrier;
	logic [CODE_W-1:0] latched_code;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic scanner_reset();
		gap_ticks = RST_SCAN_GAP;
		settle_ticks = RST_DEBOUNCE;
		step_ticks = RST_HOLD_STEP;
		press_samples = RST_HOLD_STEPS;
		baud_ticks = RST_BIT_TICKS;
		scan_phase = PH_GAP;
		wait_count = '0;
		hold_samples = '0;
		cur_row = '0;
		cur_col = '0;
		key_down = '0;
		col_snapshot = '0;
		tx_shift = '0;
		tx_bit = '0;
		tx_busy = 1'b0;
		carrier = 1'b0;
		latched_code = '0;
	endtask

	// Counts one tick of a wait; a period of zero behaves as one.
	function automatic logic period_elapsed(input logic [TICK_W-1:0] period);
		if ({1'b0, wait_count} + 17'd1 >= {1'b0, period}) begin
			wait_count = '0;
			return 1'b1;
		end
		wait_count = wait_count + 16'd1;
		return 1'b0;
	endfunction

	// Step to the next row, or close the column and go to the gap or the frame.
	task automatic advance_row();
		wait_count = '0;
		if (cur_row != 2'd3 && !tx_busy) begin
			cur_row = cur_row + 2'd1;
			scan_phase = PH_SETTLE;
		end else begin
			cur_row = '0;
			cur_col = cur_col + 2'd1;
			if (tx_busy) begin
				scan_phase = PH_TX;
				carrier = 1'b1;
				tx_bit = '0;
			end else begin
				scan_phase = PH_GAP;
			end
		end
	endtask

	// Advances the scanner copy by one tick and queues the output it shows.
	task automatic scan_tick(input logic [ROW_W-1:0] rows);
		logic [3:0] key;
		logic lifted;
		logic sent;
		result_t res;
		key = {cur_row, cur_col};
		lifted = rows[cur_row];
		sent = 1'b0;
		case (scan_phase)
		PH_GAP: begin
			if (period_elapsed(gap_ticks)) begin
				for (int r = 0; r < 4; r++) begin
					col_snapshot[r] = key_down[{2'(r), cur_col}];
				end
				scan_phase = PH_SETTLE;
			end
		end
		PH_SETTLE: begin
			if (period_elapsed(settle_ticks)) begin
				if (!lifted) begin
					key_down[key] = 1'b1;
					hold_samples = '0;
					scan_phase = PH_HOLD;
				end else begin
					key_down[key] = 1'b0;
					advance_row();
				end
			end
		end
		PH_HOLD: begin
			if (period_elapsed(step_ticks)) begin
				if (hold_samples < press_samples) begin
					hold_samples = hold_samples + 12'd1;
					// An early release forgets the key and ends the hold at the next sample.
					if (lifted) begin
						key_down[key] = 1'b0;
						hold_samples = press_samples;
					end
				end else begin
					hold_samples = '0;
					// Only a key that was up at this column's last scan is sent.
					if (key_down[key] && !col_snapshot[cur_row]) begin
						latched_code = (key < 4'd10) ? ASCII_ZERO + {4'd0, key}
							: ASCII_A + {4'd0, key} - 8'd10;
						tx_shift = latched_code;
						tx_busy = 1'b1;
						sent = 1'b1;
						keys_latched++;
					end
					advance_row();
				end
			end
		end
		default: begin
			if (period_elapsed(baud_ticks)) begin
				if (tx_bit >= BIT_IDX_W'(FRAME_BITS)) begin
					carrier = 1'b0;
					tx_bit = '0;
					tx_busy = 1'b0;
					scan_phase = PH_GAP;
				end else begin
					carrier = ~tx_shift[tx_bit[2:0]];
					tx_bit = tx_bit + 4'd1;
				end
			end
		end
		endcase
		res.column_drive = (scan_phase == PH_SETTLE || scan_phase == PH_HOLD)
			? (4'b0001 << cur_col) : 4'b0000;
		res.carrier_on = carrier;
		res.key_sent = sent;
		res.key_code = latched_code;
		res.transmitting = tx_busy;
		tick_results.push_back(res);
	endtask

	// One register write; the scanner copy takes the same value.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
		REG_SCAN_GAP: gap_ticks = value;
		REG_DEBOUNCE: settle_ticks = value;
		REG_HOLD_STEP: step_ticks = value;
		REG_HOLD_STEPS: press_samples = value[HOLD_W-1:0];
		REG_BIT_TICKS: baud_ticks = value;
		default: ;
		endcase
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] gap, input logic [CFG_DATA_W-1:0] settle,
			input logic [CFG_DATA_W-1:0] step, input logic [CFG_DATA_W-1:0] samples,
			input logic [CFG_DATA_W-1:0] baud);
		write_reg(REG_SCAN_GAP, gap);
		write_reg(REG_DEBOUNCE, settle);
		write_reg(REG_HOLD_STEP, step);
		write_reg(REG_HOLD_STEPS, samples);
		write_reg(REG_BIT_TICKS, baud);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every row sample is sent and every output beat has been checked.
	task automatic wait_idle();
		do @(negedge clk);
		while (row_stream.size() != 0 || in_ch.valid || tick_results.size() != 0);
	endtask

	// Mostly key presses of random length, with bounces and some line noise.
	task automatic queue_presses(input int count);
		int added;
		int len;
		logic [1:0] row;
		logic [ROW_W-1:0] held;
		added = 0;
		while (added < count) begin
			if ($urandom_range(0, 99) < 70) begin
				row = 2'($urandom_range(0, 3));
				held = ~(4'b0001 << row);
				if ($urandom_range(0, 3) == 0) begin
					held = held & 4'($urandom_range(0, 15));
				end
				len = $urandom_range(1, 60);
				repeat (len) begin
					// A rare bounce lifts the row for one tick.
					if ($urandom_range(0, 19) == 0) begin
						row_stream.push_back(held | (4'b0001 << row));
					end else begin
						row_stream.push_back(held);
					end
					added++;
				end
				repeat ($urandom_range(0, 12)) begin
					row_stream.push_back('1);
					added++;
				end
			end else begin
				repeat ($urandom_range(1, 8)) begin
					row_stream.push_back(4'($urandom_range(0, 15)));
					added++;
				end
			end
		end
	endtask

	// Sender: bursts of beats with random gaps; valid holds until the beat is taken.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.row_levels <= '1;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				scan_tick(in_ch.row_levels);
				void'(row_stream.pop_front());
				ticks_sent++;
				if (burst_left > 0) begin
					burst_left--;
				end
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (row_stream.size() != 0) begin
					in_ch.valid <= 1'b1;
					in_ch.row_levels <= row_stream[0];
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [CODE_W-1:0] want,
			input logic [CODE_W-1:0] got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// Receiver: checks each output beat and stalls in modes that change at random.
	result_t head_result;
	int holdoff_left = 0;
	int mode_left = 0;
	int stall_mode = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (tick_results.size() == 0) begin
					errors++;
					$display("%0t: output beat with nothing expected, got %0h %0h %0h %0h %0h",
						$time, out_ch.column_drive, out_ch.carrier_on, out_ch.key_sent,
						out_ch.key_code, out_ch.transmitting);
				end else begin
					head_result = tick_results.pop_front();
					check_field("column_drive", CODE_W'(head_result.column_drive),
						CODE_W'(out_ch.column_drive));
					check_field("carrier_on", CODE_W'(head_result.carrier_on),
						CODE_W'(out_ch.carrier_on));
					check_field("key_sent", CODE_W'(head_result.key_sent),
						CODE_W'(out_ch.key_sent));
					check_field("key_code", head_result.key_code, out_ch.key_code);
					check_field("transmitting", CODE_W'(head_result.transmitting),
						CODE_W'(out_ch.transmitting));
				end
				beats_checked++;
				// Now and then hold off long enough for the block to back up its input.
				if (beats_checked % 400 == 250) begin
					holdoff_left = HOLDOFF_CYCLES;
				end
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				out_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(8, 40);
				end
				mode_left--;
				case (stall_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= 1'($urandom_range(0, 1));
				default: out_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d beats still expected", $time, tick_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		cfg_we = 1'b0;
		cfg_index = REG_SCAN_GAP;
		cfg_wdata = '0;
		arst_n = 1'b0;
		scanner_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: all rows up, all down, each row alone in both senses.
		row_stream = '{4'h0, 4'hF, 4'hE, 4'hD, 4'hB, 4'h7, 4'h1, 4'h2, 4'h4, 4'h8, 4'hA, 4'h5};
		wait_idle();

		// Shortest periods: one clean press of the first key, then release.
		configure(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		repeat (8) row_stream.push_back(4'hE);
		repeat (5) row_stream.push_back(4'hF);
		wait_idle();

		// Same settings, random presses, with a full pause of the sender halfway.
		queue_presses(100);
		wait_idle();
		queue_presses(100);
		wait_idle();

		// Zero periods and zero hold steps.
		configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		queue_presses(150);
		wait_idle();

		configure(16'd2, 16'd3, 16'd2, 16'd4, 16'd2);
		queue_presses(200);
		wait_idle();

		// Largest periods; the hold step count keeps only its low twelve bits.
		write_reg(REG_SPARE_LO, 16'h0001);
		write_reg(REG_SPARE_HI, 16'hFFFF);
		configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_presses(60);
		wait_idle();

		// Periods drop well below counts already reached.
		configure(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
			16'($urandom_range(1, 4)), 16'($urandom_range(1, 6)),
			16'($urandom_range(1, 4)));
		queue_presses(200);
		wait_idle();

		configure(16'd1, 16'd2, 16'd1, 16'd12, 16'd3);
		queue_presses(200);
		wait_idle();

		configure(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
			16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
			16'($urandom_range(0, 3)));
		queue_presses(140);
		wait_idle();

		repeat (10) @(posedge clk);
		$display("Sent %0d row ticks under eight register settings with sender gaps and output stalls;",
			ticks_sent);
		$display("checked %0d output beats, %0d keys latched and framed.", beats_checked, keys_latched);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: keypad_longpress_serial_sender.f
+incdir+src
src/kls_pkg.sv
src/kls_in_if.sv
src/kls_out_if.sv
src/keypad_longpress_serial_sender.sv
bench/keypad_longpress_serial_sender_tb.sv
